>>> rtl/core/bat_pkg.sv
// Shared constants for the buddy allocator tree: node mark codes,
// result status codes and the fixed field widths. No dependencies.
`default_nettype none
package bat_pkg;
  localparam int TREE_LEVELS_DEF = 12;
  localparam int ORDER_W  = 4;
  localparam int PAGE_W   = 12;
  localparam int STATUS_W = 3;
  localparam int LFP_W    = 13;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_SPLIT = 2'd1;
  localparam logic [1:0] MARK_FULL  = 2'h3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
endpackage
`default_nettype wire

>>> rtl/core/bat_node_mem.sv
// Node mark memory: one write port, one read port, registered read data.
// Depends on bat_pkg for the default tree depth.
`default_nettype none
module bat_node_mem
  import bat_pkg::*;
#(
  parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [TREE_LEVELS:0] waddr,
  input  wire logic [1:0]           wdata,
  input  wire logic [TREE_LEVELS:0] raddr,
  output logic      [1:0]           rdata
);
  localparam int NODE_COUNT = 1 << (TREE_LEVELS + 1);

  logic [1:0] mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/buddy_allocator_tree.sv
// Buddy allocator top level: request sequencer, backtrack stack and the
// node mark memory. Depends on bat_pkg and bat_node_mem.
//
// Usage: a request (action, order, page_index) transfers at a rising edge
// with start high and busy low. Exactly one result (status, block_page)
// appears for one cycle with done high; the receiver cannot stall it and
// must take it in that cycle. One request is in flight at a time.
// Sequencing: an order above the tree depth is answered from idle. An
// allocate walks down the tree, reading an empty node in S_SA/S_SB and a
// split one and its children in S_SA to S_SD, popping the backtrack stack
// (S_BT) on a dead end, then fixes marks up to the root in S_AFA/S_AFB per
// level. A free checks the node (S_FRA/S_FRB), then merges upward in
// S_FFA/S_FFB/S_FFC per level; the single memory read port is registered.
// Reset: rst (synchronous) clears lowest_free_page and starts a clearing
// pass that marks all 2^(TREE_LEVELS+1) nodes full, one per cycle; busy
// stays high throughout.
// Configuration: cfg_we with cfg_wdata writes lowest_free_page; write it
// only while the block is idle.
`default_nettype none
module buddy_allocator_tree
  import bat_pkg::*;
#(
  parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                action,
  input  wire logic [ORDER_W-1:0]  order,
  input  wire logic [PAGE_W-1:0]   page_index,
  input  wire logic                cfg_we,
  input  wire logic [LFP_W-1:0]    cfg_wdata,
  output logic                     done,
  output logic [STATUS_W-1:0]      status,
  output logic [PAGE_W-1:0]        block_page
);
  localparam int NW = TREE_LEVELS + 1;               // node index bits
  localparam int DW = $clog2(TREE_LEVELS + 1);       // depth bits
  localparam int TW = $clog2(TREE_LEVELS + 1);       // stack fill bits
  localparam int IW = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SA   = 4'd2;   // issue read of current node
  localparam logic [3:0] S_SB   = 4'd3;   // inspect current node
  localparam logic [3:0] S_SC   = 4'd4;   // left child mark arrives
  localparam logic [3:0] S_SD   = 4'd5;   // right child mark arrives
  localparam logic [3:0] S_BT   = 4'd6;   // pop the backtrack stack
  localparam logic [3:0] S_AFA  = 4'd7;   // alloc fix-up: read buddy
  localparam logic [3:0] S_AFB  = 4'd8;   // alloc fix-up: write parent
  localparam logic [3:0] S_FRA  = 4'd9;   // free: read node
  localparam logic [3:0] S_FRB  = 4'd10;  // free: check node
  localparam logic [3:0] S_FFA  = 4'd11;  // free fix-up: read buddy
  localparam logic [3:0] S_FFB  = 4'd12;  // free fix-up: read parent
  localparam logic [3:0] S_FFC  = 4'd13;  // free fix-up: merge decision

  logic [3:0]         state;
  logic [LFP_W-1:0]   lowest_free_page;
  logic [NW-1:0]      clr_cnt;
  logic [NW-1:0]      cur;
  logic [DW-1:0]      lv;
  logic [DW-1:0]      dep;
  logic [ORDER_W-1:0] ord;
  logic [1:0]         mk;      // mark of the node just handled
  logic [1:0]         lmark;   // left child or buddy mark
  logic [TW-1:0]      top;
  logic [PAGE_W-1:0]  blk;
  logic [NW-1:0]      stk_node  [TREE_LEVELS];
  logic [DW-1:0]      stk_depth [TREE_LEVELS];

  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [NW-1:0] mem_raddr;
  logic [1:0]    rdata;

  bat_node_mem #(.TREE_LEVELS(TREE_LEVELS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);

  // Request decode at the transfer edge and per-state decode for the walk.
  logic          order_big;
  logic          addr_bad;
  logic [DW-1:0] req_dep;
  logic [NW-1:0] free_node;
  logic [31:0]   blk_wide;
  logic [1:0]    alloc_mark;
  logic          found;
  logic [IW-1:0] pop_idx;

  assign order_big = 32'(order) > TREE_LEVELS;
  assign addr_bad  = ({1'b0, page_index} < lowest_free_page) ||
                     ((page_index >> TREE_LEVELS) != '0);
  assign req_dep   = DW'(TREE_LEVELS) - DW'(order);
  assign free_node = (NW'(1) << req_dep) | NW'(page_index >> order);
  assign blk_wide  = 32'(cur ^ (NW'(1) << dep)) << ord;
  assign alloc_mark = (mk == MARK_FULL && rdata == MARK_FULL) ? MARK_FULL : MARK_SPLIT;
  assign found     = (lv == dep) && (rdata == MARK_EMPTY);
  assign pop_idx   = IW'(top - TW'(1));

  // Memory port steering per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = MARK_FULL;
    mem_raddr = cur;
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_SB: begin
        mem_raddr = cur << 1;
        mem_we    = found;
      end
      S_SC:  mem_raddr = (cur << 1) | NW'(1);
      S_AFA: mem_raddr = cur ^ NW'(1);
      S_AFB: begin
        mem_we    = 1'b1;
        mem_waddr = cur >> 1;
        mem_wdata = alloc_mark;
      end
      S_FRB: begin
        mem_we    = (rdata == MARK_FULL);
        mem_wdata = MARK_EMPTY;
      end
      S_FFA: mem_raddr = cur ^ NW'(1);
      S_FFB: mem_raddr = cur >> 1;
      S_FFC: begin
        mem_waddr = cur >> 1;
        if (rdata == MARK_FULL) begin
          mem_we    = 1'b1;
          mem_wdata = MARK_SPLIT;
        end else if (rdata == MARK_SPLIT && mk == MARK_EMPTY && lmark == MARK_EMPTY) begin
          mem_we    = 1'b1;
          mem_wdata = MARK_EMPTY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state            <= S_CLR;
      clr_cnt          <= '0;
      top              <= '0;
      lowest_free_page <= '0;
      status           <= ST_OK;
      block_page       <= '0;
    end else begin
      if (cfg_we) begin
        lowest_free_page <= cfg_wdata;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ord <= order;
            dep <= req_dep;
            if (order_big) begin
              done <= 1'b1; status <= ST_ORDER; block_page <= '0;
            end else if (action == ACT_ALLOC) begin
              cur   <= NW'(1);
              lv    <= '0;
              top   <= '0;
              state <= S_SA;
            end else if (addr_bad) begin
              done <= 1'b1; status <= ST_REJECTED; block_page <= '0;
            end else begin
              cur   <= free_node;
              state <= S_FRA;
            end
          end
        end
        S_SA: state <= S_SB;
        S_SB: begin
          if (rdata == MARK_FULL) begin
            state <= S_BT;
          end else if (lv == dep) begin
            if (found) begin
              blk   <= blk_wide[PAGE_W-1:0];
              mk    <= MARK_FULL;
              state <= S_AFA;
            end else begin
              state <= S_BT;
            end
          end else if (rdata == MARK_EMPTY) begin
            cur   <= cur << 1;
            lv    <= lv + DW'(1);
            state <= S_SA;
          end else if (rdata == MARK_SPLIT) begin
            state <= S_SC;
          end else begin
            state <= S_BT;
          end
        end
        S_SC: begin
          lmark <= rdata;
          state <= S_SD;
        end
        S_SD: begin
          priority if (lmark == MARK_SPLIT && rdata == MARK_SPLIT) begin
            if (32'(top) >= TREE_LEVELS) begin
              done <= 1'b1; status <= ST_NO_SPACE; block_page <= '0;
              state <= S_IDLE;
            end else begin
              stk_node[IW'(top)]  <= cur;
              stk_depth[IW'(top)] <= lv;
              top   <= top + TW'(1);
              cur   <= cur << 1;
              lv    <= lv + DW'(1);
              state <= S_SA;
            end
          end else if (lmark == MARK_EMPTY) begin
            cur <= cur << 1; lv <= lv + DW'(1); state <= S_SA;
          end else if (rdata == MARK_EMPTY) begin
            cur <= (cur << 1) | NW'(1); lv <= lv + DW'(1); state <= S_SA;
          end else if (lmark == MARK_FULL && rdata == MARK_SPLIT) begin
            cur <= (cur << 1) | NW'(1); lv <= lv + DW'(1); state <= S_SA;
          end else if (rdata == MARK_FULL && lmark == MARK_SPLIT) begin
            cur <= cur << 1; lv <= lv + DW'(1); state <= S_SA;
          end else begin
            state <= S_BT;
          end
        end
        S_BT: begin
          if (top == '0) begin
            done <= 1'b1; status <= ST_NO_SPACE; block_page <= '0;
            state <= S_IDLE;
          end else begin
            top   <= top - TW'(1);
            cur   <= (stk_node[pop_idx] << 1) | NW'(1);
            lv    <= stk_depth[pop_idx] + DW'(1);
            state <= S_SA;
          end
        end
        S_AFA: begin
          if (cur == NW'(1)) begin
            done <= 1'b1; status <= ST_OK; block_page <= blk;
            state <= S_IDLE;
          end else begin
            state <= S_AFB;
          end
        end
        S_AFB: begin
          mk    <= alloc_mark;
          cur   <= cur >> 1;
          state <= S_AFA;
        end
        S_FRA: state <= S_FRB;
        S_FRB: begin
          if (rdata != MARK_FULL) begin
            done <= 1'b1; status <= ST_NOT_ALLOC; block_page <= '0;
            state <= S_IDLE;
          end else begin
            mk    <= MARK_EMPTY;
            state <= S_FFA;
          end
        end
        S_FFA: begin
          if (cur == NW'(1)) begin
            done <= 1'b1; status <= ST_OK; block_page <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_FFB;
          end
        end
        S_FFB: begin
          lmark <= rdata;
          state <= S_FFC;
        end
        S_FFC: begin
          cur <= cur >> 1;
          if (rdata == MARK_FULL) begin
            mk <= MARK_SPLIT; state <= S_FFA;
          end else if (rdata == MARK_SPLIT) begin
            if (mk == MARK_EMPTY && lmark == MARK_EMPTY) begin
              mk <= MARK_EMPTY; state <= S_FFA;
            end else begin
              done <= 1'b1; status <= ST_OK; block_page <= '0;
              state <= S_IDLE;
            end
          end else begin
            mk <= rdata; state <= S_FFA;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only follows a transfer or ongoing work.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a request");

  // An oversized order answers at once.
  a_order_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && order_big) |=> (done && status == ST_ORDER))
    else $error("order too big not answered");

  // Only a successful allocate carries a page.
  a_block_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (block_page == '0))
    else $error("block_page nonzero on failure");

  // The stack never exceeds its depth.
  a_stack: assert property (@(posedge clk) disable iff (rst)
    32'(top) <= TREE_LEVELS)
    else $error("stack overflow");
endmodule
`default_nettype wire
